@@ rtl/core/anbs_pkg.sv @@
// ----------------------------------------------------------------------------
// anbs_pkg
// Shared constants and field widths of the Annex B NAL unit splitter.
// ----------------------------------------------------------------------------
package anbs_pkg;

  // Fixed result field widths
  localparam int unsigned IDX_W  = 32;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned PLEN_W = 3;
  localparam int unsigned REF_W  = 2;
  localparam int unsigned TYPE_W = 5;

  // Bits of the result word that do not depend on the length width
  localparam int unsigned FIXED_W = IDX_W + POS_W + PLEN_W + 1 + REF_W + TYPE_W + 1 + 1;

  // Start code bytes
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;

  // Prefix lengths
  localparam logic [PLEN_W-1:0] PLEN_SHORT = 3'd3;
  localparam logic [PLEN_W-1:0] PLEN_LONG  = 3'd4;

  // Window zero-run code: three zeros ahead of the current byte
  localparam logic [1:0] ZRUN_THREE = 2'd3;

endpackage

@@ rtl/core/anbs_out_buf.sv @@
// ----------------------------------------------------------------------------
// anbs_out_buf
// Two-entry result buffer: a main output register and a skid register, so
// the parser keeps taking bytes while a descriptor waits on the output.
// ----------------------------------------------------------------------------
module anbs_out_buf #(
  parameter int unsigned WIDTH = 104
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             ready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [WIDTH-1:0] out_tdata
);

  logic             main_valid_r;
  logic             skid_valid_r;
  logic [WIDTH-1:0] main_data_r;
  logic [WIDTH-1:0] skid_data_r;
  logic             pop;

  assign pop        = main_valid_r && out_tready;
  // A push arriving behind a held main entry may take the skid slot, so hold
  // off the next byte, whose descriptor could then find both entries full
  assign ready      = !skid_valid_r && !(push && main_valid_r);
  assign out_tvalid = main_valid_r;
  assign out_tdata  = main_data_r;

  // Control: refill the main register from skid or from a new push
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_data_r <= skid_data_r;
      end else begin
        main_data_r <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  // Skid only fills behind a held main entry
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry without main entry");

  // A stalled transfer keeps its entry
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    main_valid_r && !out_tready |=> main_valid_r)
    else $error("result dropped while stalled");

  // Never push into a full buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("push while both entries are full");

endmodule

@@ rtl/core/anbs_parser.sv @@
// ----------------------------------------------------------------------------
// anbs_parser
// Start code detection, unit bookkeeping and descriptor assembly. Updates
// all parse state in one pass per accepted byte.
// ----------------------------------------------------------------------------
module anbs_parser #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [7:0]          in_byte,
  input  logic                in_eos,
  output logic                res_valid,
  output logic [((anbs_pkg::FIXED_W + LENGTH_BITS + 7) / 8) * 8 - 1:0] res_data
);

  localparam int unsigned OUT_W = ((anbs_pkg::FIXED_W + LENGTH_BITS + 7) / 8) * 8;
  localparam int unsigned LB = LENGTH_BITS;

  // Result word bit positions
  localparam int unsigned P_IDX  = 0;
  localparam int unsigned P_OFS  = P_IDX + anbs_pkg::IDX_W;
  localparam int unsigned P_PLEN = P_OFS + anbs_pkg::POS_W;
  localparam int unsigned P_FORB = P_PLEN + anbs_pkg::PLEN_W;
  localparam int unsigned P_REF  = P_FORB + 1;
  localparam int unsigned P_TYPE = P_REF + anbs_pkg::REF_W;
  localparam int unsigned P_LEN  = P_TYPE + anbs_pkg::TYPE_W;
  localparam int unsigned P_SAT  = P_LEN + LB;
  localparam int unsigned P_ERR  = P_SAT + 1;

  localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};

  typedef enum logic [1:0] {
    PH_LEAD     = 2'd0,
    PH_HUNT     = 2'd1,
    PH_UNIT     = 2'd2,
    PH_UNIT_ERR = 2'd3
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  logic [23:0]                  win_r, win_nxt;
  logic [2:0]                   pcnt_r, pcnt_nxt;
  logic [LB-1:0]                bytes_r, bytes_nxt;
  logic                         sat_r, sat_nxt;
  logic [7:0]                   hdr_r, hdr_nxt;
  logic                         hseen_r, hseen_nxt;
  logic [anbs_pkg::PLEN_W-1:0]  plen_r, plen_nxt;
  logic [anbs_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [anbs_pkg::POS_W-1:0]   start_r, start_nxt;
  logic [anbs_pkg::IDX_W-1:0]   cnt_r, cnt_nxt;

  logic                         res_valid_nxt;
  logic [OUT_W-1:0]             res_data_nxt;

  logic [1:0]                   zrun;
  logic                         code;
  logic [anbs_pkg::PLEN_W-1:0]  plen_found;
  logic [2:0]                   add_n;
  logic [LB:0]                  sum;
  logic [LB-1:0]                bytes_add;
  logic                         sat_add;
  logic                         open_req;
  logic                         open_err;
  logic [anbs_pkg::PLEN_W-1:0]  open_plen;
  logic                         emit;
  logic [7:0]                   hdr_emit;

  // Zero run ahead of the current byte and start code detect
  always_comb begin
    if (win_r[7:0] != anbs_pkg::BYTE_ZERO) begin
      zrun = 2'd0;
    end else if (win_r[15:8] != anbs_pkg::BYTE_ZERO) begin
      zrun = 2'd1;
    end else if (win_r[23:16] != anbs_pkg::BYTE_ZERO) begin
      zrun = 2'd2;
    end else begin
      zrun = anbs_pkg::ZRUN_THREE;
    end
  end

  assign code       = (in_byte == anbs_pkg::BYTE_ONE) && zrun[1];
  assign plen_found = (zrun == anbs_pkg::ZRUN_THREE) ? anbs_pkg::PLEN_LONG
                                                     : anbs_pkg::PLEN_SHORT;

  // Payload bytes released by this byte: held zeros join once they are
  // known not to be a start code
  always_comb begin
    if (phase_r == PH_UNIT || phase_r == PH_UNIT_ERR) begin
      if (code) begin
        add_n = 3'd0;
      end else if (in_byte != anbs_pkg::BYTE_ZERO || in_eos) begin
        add_n = {1'b0, zrun} + 3'd1;
      end else if (zrun == anbs_pkg::ZRUN_THREE) begin
        add_n = 3'd1;
      end else begin
        add_n = 3'd0;
      end
    end else begin
      add_n = 3'd0;
    end
  end

  // Saturating length add
  assign sum       = {1'b0, bytes_r} + {{(LB-2){1'b0}}, add_n};
  assign sat_add   = sat_r || sum[LB];
  assign bytes_add = sum[LB] ? LEN_MAX : sum[LB-1:0];

  // Next state and descriptor
  always_comb begin
    phase_nxt     = phase_r;
    win_nxt       = {win_r[15:0], in_byte};
    pcnt_nxt      = pcnt_r;
    bytes_nxt     = bytes_r;
    sat_nxt       = sat_r;
    hdr_nxt       = hdr_r;
    hseen_nxt     = hseen_r;
    plen_nxt      = plen_r;
    pos_nxt       = pos_r + 1'b1;
    start_nxt     = start_r;
    cnt_nxt       = cnt_r;
    open_req      = 1'b0;
    open_err      = 1'b0;
    open_plen     = plen_found;
    emit          = 1'b0;
    res_data_nxt  = '0;

    unique case (phase_r)
      PH_LEAD: begin
        if (pcnt_r <= 3'd1) begin
          if (in_byte == anbs_pkg::BYTE_ZERO) begin
            pcnt_nxt = pcnt_r + 3'd1;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end else if (pcnt_r == 3'd2) begin
          if (in_byte == anbs_pkg::BYTE_ONE) begin
            open_req  = !in_eos;
            open_plen = anbs_pkg::PLEN_SHORT;
          end else if (in_byte == anbs_pkg::BYTE_ZERO) begin
            pcnt_nxt = 3'd3;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end else if (pcnt_r == 3'd3 && in_byte == anbs_pkg::BYTE_ONE) begin
          open_req  = !in_eos;
          open_plen = anbs_pkg::PLEN_LONG;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_HUNT: begin
        open_req = code && !in_eos;
        open_err = 1'b1;
      end
      PH_UNIT, PH_UNIT_ERR: begin
        if (!hseen_r) begin
          hdr_nxt   = in_byte;
          hseen_nxt = 1'b1;
        end
        bytes_nxt = bytes_add;
        sat_nxt   = sat_add;
        emit      = code || in_eos;
        open_req  = code && !in_eos;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase

    // Empty units report a zero header
    hdr_emit = (bytes_add == '0 && !sat_add) ? 8'h00 : hdr_nxt;

    // Assemble descriptor
    res_data_nxt[P_IDX +: anbs_pkg::IDX_W]   = cnt_r;
    res_data_nxt[P_OFS +: anbs_pkg::POS_W]   = start_r;
    res_data_nxt[P_PLEN +: anbs_pkg::PLEN_W] = plen_r;
    res_data_nxt[P_FORB]                     = hdr_emit[7];
    res_data_nxt[P_REF +: anbs_pkg::REF_W]   = hdr_emit[6:5];
    res_data_nxt[P_TYPE +: anbs_pkg::TYPE_W] = hdr_emit[4:0];
    res_data_nxt[P_LEN +: LB]                = bytes_add;
    res_data_nxt[P_SAT]                      = sat_add;
    res_data_nxt[P_ERR]                      = (phase_r == PH_UNIT_ERR);
    res_valid_nxt                            = emit && in_fire;

    if (emit) begin
      cnt_nxt = cnt_r + 1'b1;
    end

    // Open a new unit after its start code
    if (open_req) begin
      start_nxt = pos_r - {{(anbs_pkg::POS_W-anbs_pkg::PLEN_W){1'b0}},
                           (open_plen - 3'd1)};
      plen_nxt  = open_plen;
      bytes_nxt = '0;
      sat_nxt   = 1'b0;
      hdr_nxt   = 8'h00;
      hseen_nxt = 1'b0;
      phase_nxt = open_err ? PH_UNIT_ERR : PH_UNIT;
    end

    // End of stream: return to the reset state
    if (in_eos) begin
      phase_nxt = PH_LEAD;
      win_nxt   = 24'hFFFFFF;
      pcnt_nxt  = 3'd0;
      bytes_nxt = '0;
      sat_nxt   = 1'b0;
      hdr_nxt   = 8'h00;
      hseen_nxt = 1'b0;
      plen_nxt  = anbs_pkg::PLEN_SHORT;
      pos_nxt   = '0;
      start_nxt = '0;
      cnt_nxt   = '0;
    end
  end

  // State and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LEAD;
      win_r     <= 24'hFFFFFF;
      pcnt_r    <= 3'd0;
      bytes_r   <= '0;
      sat_r     <= 1'b0;
      hdr_r     <= 8'h00;
      hseen_r   <= 1'b0;
      plen_r    <= anbs_pkg::PLEN_SHORT;
      pos_r     <= '0;
      start_r   <= '0;
      cnt_r     <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_nxt;
      if (in_fire) begin
        phase_r <= phase_nxt;
        win_r   <= win_nxt;
        pcnt_r  <= pcnt_nxt;
        bytes_r <= bytes_nxt;
        sat_r   <= sat_nxt;
        hdr_r   <= hdr_nxt;
        hseen_r <= hseen_nxt;
        plen_r  <= plen_nxt;
        pos_r   <= pos_nxt;
        start_r <= start_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_data <= res_data_nxt;
  end

  // Final byte restarts the stream
  a_eos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_eos |=> phase_r == PH_LEAD && pos_r == '0 && cnt_r == '0)
    else $error("stream state not cleared after final byte");

  // Saturation pins the length at its maximum
  a_sat_pinned: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> bytes_r == LEN_MAX)
    else $error("saturated length below maximum");

  // Every descriptor carries a three or four byte prefix
  a_plen_legal: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res_data[P_PLEN +: anbs_pkg::PLEN_W] == anbs_pkg::PLEN_SHORT ||
                  res_data[P_PLEN +: anbs_pkg::PLEN_W] == anbs_pkg::PLEN_LONG)
    else $error("illegal prefix length in descriptor");

endmodule

@@ rtl/core/annexb_nal_unit_splitter.sv @@
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter
// Splits an H.264 Annex B byte stream into NAL unit descriptors.
// ----------------------------------------------------------------------------
// One stream byte is taken per clock cycle, sustained, whenever the output
// side keeps pace; the start code compare and all counter updates complete
// in the cycle the byte is taken. A descriptor is registered in the parser
// at the edge that takes the byte closing its unit (the next start code, or
// the byte marked last) and moves from there into the output register, or
// into the skid entry while the output register is held. A two-entry output
// buffer decouples the sides; input stalls while the skid entry is full, or
// while a descriptor sits on the output and another is on its way in. After
// the last byte of a stream the index and offsets restart from zero.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  // in_tdata: data_byte[7:0]
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tlast,
  // out_tdata from bit 0 up: unit_index[32], unit_offset[32], prefix_length[3],
  // forbidden_zero[1], reference_idc[2], unit_type[5],
  // payload_length[LENGTH_BITS], length_saturated[1], framing_error[1], zero fill
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [((anbs_pkg::FIXED_W + LENGTH_BITS + 7) / 8) * 8 - 1:0] out_tdata
);

  localparam int unsigned OUT_W = ((anbs_pkg::FIXED_W + LENGTH_BITS + 7) / 8) * 8;

  logic             in_fire;
  logic             res_valid;
  logic [OUT_W-1:0] res_data;

  assign in_fire = in_tvalid && in_tready;

  // Parse one byte per transfer
  anbs_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_byte   (in_tdata),
    .in_eos    (in_tlast),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  // Buffer descriptors toward the output
  anbs_out_buf #(
    .WIDTH (OUT_W)
  ) u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res_data),
    .ready      (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ sim/annexb_nal_unit_splitter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter_tb
// Self-checking testbench for the Annex B NAL unit splitter.
// ----------------------------------------------------------------------------
// Byte streams are pushed into the splitter in bursts with random gaps, while
// the descriptor side stalls on its own pattern. A parser model inside the
// bench tracks every accepted byte and queues the descriptor each closed unit
// must produce; every descriptor transfer is checked field by field against
// the oldest queued one. Directed streams cover both prefix forms, empty
// units, a start code on the final byte, framing errors and long units with
// held zeros inside; random streams follow.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter_tb;

  localparam int unsigned LEN_BITS       = 24;
  localparam longint     LEN_MAX        = (64'd1 << LEN_BITS) - 1;
  localparam int unsigned OUT_W          = ((anbs_pkg::FIXED_W + LEN_BITS + 7) / 8) * 8;
  localparam int unsigned LEN_LSB        = anbs_pkg::IDX_W + anbs_pkg::POS_W +
                                           anbs_pkg::PLEN_W + 1 + anbs_pkg::REF_W +
                                           anbs_pkg::TYPE_W;
  localparam int unsigned HDR_LSB        = anbs_pkg::IDX_W + anbs_pkg::POS_W +
                                           anbs_pkg::PLEN_W;
  localparam int          RANDOM_ITEMS   = 1590;
  localparam int          WATCHDOG_LIMIT = 1000;
  localparam int          TAIL_CYCLES    = 20;
  localparam int          REPORT_LIMIT   = 10;

  typedef enum logic [1:0] {
    SEEK_LEAD,
    HUNTING,
    IN_UNIT,
    IN_UNIT_HUNTED
  } parse_state_t;

  typedef struct {
    logic [anbs_pkg::IDX_W-1:0]  index;
    logic [anbs_pkg::POS_W-1:0]  offset;
    logic [anbs_pkg::PLEN_W-1:0] plen;
    logic                        forbidden;
    logic [anbs_pkg::REF_W-1:0]  ref_idc;
    logic [anbs_pkg::TYPE_W-1:0] nal_type;
    logic [LEN_BITS-1:0]         length;
    logic                        saturated;
    logic                        framing_err;
  } unit_desc_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = 8'h00;
  logic             in_tlast   = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  annexb_nal_unit_splitter #(
    .LENGTH_BITS(LEN_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Parser model state
  logic [23:0]                 recent_bytes;
  parse_state_t                parse_state;
  logic [2:0]                  lead_zeros;
  logic [LEN_BITS-1:0]         unit_len;
  logic                        unit_sat;
  logic [7:0]                  nal_header;
  logic                        header_taken;
  logic [anbs_pkg::PLEN_W-1:0] unit_plen;
  logic [anbs_pkg::POS_W-1:0]  byte_pos;
  logic [anbs_pkg::POS_W-1:0]  unit_pos;
  logic [anbs_pkg::IDX_W-1:0]  units_closed;

  unit_desc_t  expected_units[$];
  logic [7:0]  stream_buf[$];
  int          items_sent  = 0;
  int          burst_left  = 0;
  int          mismatches  = 0;
  int          idle_cycles = 0;

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  function automatic void restart_parser();
    recent_bytes = 24'hFFFFFF;
    parse_state  = SEEK_LEAD;
    lead_zeros   = 3'd0;
    unit_len     = '0;
    unit_sat     = 1'b0;
    nal_header   = 8'h00;
    header_taken = 1'b0;
    unit_plen    = anbs_pkg::PLEN_SHORT;
    byte_pos     = '0;
    unit_pos     = '0;
    units_closed = '0;
  endfunction

  function automatic void open_unit(input logic [anbs_pkg::PLEN_W-1:0] plen,
                                    input parse_state_t st);
    unit_pos     = byte_pos - (anbs_pkg::POS_W'(plen) - 1);
    unit_plen    = plen;
    unit_len     = '0;
    unit_sat     = 1'b0;
    nal_header   = 8'h00;
    header_taken = 1'b0;
    parse_state  = st;
  endfunction

  function automatic void count_payload(input int unsigned n);
    longint sum;
    sum = longint'(unit_len) + n;
    if (sum > LEN_MAX) begin
      unit_len = LEN_BITS'(LEN_MAX);
      unit_sat = 1'b1;
    end else begin
      unit_len = LEN_BITS'(sum);
    end
  endfunction

  function automatic void close_unit();
    unit_desc_t d;
    logic [7:0] h;
    // an empty unit has no header byte to report
    h             = (unit_len == 0 && !unit_sat) ? 8'h00 : nal_header;
    d.index       = units_closed;
    d.offset      = unit_pos;
    d.plen        = unit_plen;
    d.forbidden   = h[7];
    d.ref_idc     = h[6:5];
    d.nal_type    = h[4:0];
    d.length      = unit_len;
    d.saturated   = unit_sat;
    d.framing_err = (parse_state == IN_UNIT_HUNTED);
    expected_units.push_back(d);
    units_closed++;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input bit eos);
    logic [1:0]                  zrun;
    bit                          code;
    bit                          ok;
    logic [anbs_pkg::PLEN_W-1:0] plen;
    zrun = (recent_bytes[7:0] != anbs_pkg::BYTE_ZERO)   ? 2'd0 :
           (recent_bytes[15:8] != anbs_pkg::BYTE_ZERO)  ? 2'd1 :
           (recent_bytes[23:16] != anbs_pkg::BYTE_ZERO) ? 2'd2 : anbs_pkg::ZRUN_THREE;
    code = (b == anbs_pkg::BYTE_ONE) && (zrun >= 2'd2);
    plen = (zrun == anbs_pkg::ZRUN_THREE) ? anbs_pkg::PLEN_LONG : anbs_pkg::PLEN_SHORT;

    case (parse_state)
      SEEK_LEAD: begin
        ok = 1'b0;
        if (lead_zeros <= 3'd1) begin
          ok = (b == anbs_pkg::BYTE_ZERO);
          if (ok) lead_zeros++;
        end else if (lead_zeros == 3'd2) begin
          if (b == anbs_pkg::BYTE_ONE) begin
            ok = 1'b1;
            if (!eos) open_unit(anbs_pkg::PLEN_SHORT, IN_UNIT);
          end else if (b == anbs_pkg::BYTE_ZERO) begin
            ok = 1'b1;
            lead_zeros = 3'd3;
          end
        end else if (b == anbs_pkg::BYTE_ONE) begin
          ok = 1'b1;
          if (!eos) open_unit(anbs_pkg::PLEN_LONG, IN_UNIT);
        end
        if (!ok) parse_state = HUNTING;
      end
      HUNTING: begin
        if (code && !eos) open_unit(plen, IN_UNIT_HUNTED);
      end
      default: begin
        if (!header_taken) begin
          nal_header   = b;
          header_taken = 1'b1;
        end
        if (code) begin
          close_unit();
          if (!eos) open_unit(plen, IN_UNIT);
        end else begin
          // held zeros count once it is clear they are not a start code
          if (b != anbs_pkg::BYTE_ZERO || eos) count_payload(zrun + 1);
          else if (zrun == anbs_pkg::ZRUN_THREE) count_payload(1);
          if (eos) close_unit();
        end
      end
    endcase

    if (eos) begin
      restart_parser();
    end else begin
      recent_bytes = {recent_bytes[15:0], b};
      byte_pos++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input bit last);
    in_tdata  <= b;
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    parse_byte(b, last);
    items_sent++;
    // close the burst with a gap, then pick the next burst length
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 30);
    end
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream_buf.size(); i++)
      send_byte(stream_buf[i], i == stream_buf.size() - 1);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic push_code(input bit long_form);
    if (long_form) stream_buf.push_back(anbs_pkg::BYTE_ZERO);
    stream_buf.push_back(anbs_pkg::BYTE_ZERO);
    stream_buf.push_back(anbs_pkg::BYTE_ZERO);
    stream_buf.push_back(anbs_pkg::BYTE_ONE);
  endtask

  function automatic logic [7:0] pick_payload_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return anbs_pkg::BYTE_ZERO;
    if (r < 30) return anbs_pkg::BYTE_ONE;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic build_random_stream();
    int kind;
    int n_units;
    int len;
    int r;
    stream_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      // noise: zero-heavy random bytes
      len = $urandom_range(1, 30);
      repeat (len) stream_buf.push_back(pick_payload_byte());
    end else begin
      // broken lead-in ahead of otherwise well-formed units
      if (kind < 20) begin
        case ($urandom_range(0, 2))
          0: begin
            stream_buf.push_back(anbs_pkg::BYTE_ZERO);
            stream_buf.push_back(anbs_pkg::BYTE_ZERO);
            stream_buf.push_back(8'h02);
          end
          1: stream_buf.push_back(8'($urandom_range(2, 255)));
          default: repeat (4) stream_buf.push_back(anbs_pkg::BYTE_ZERO);
        endcase
      end
      n_units = $urandom_range(1, 6);
      repeat (n_units) begin
        push_code($urandom_range(0, 1));
        r = $urandom_range(0, 199);
        if (r < 20)       len = 0;
        else if (r < 199) len = $urandom_range(1, 12);
        else              len = $urandom_range(250, 262);
        for (int i = 0; i < len; i++)
          stream_buf.push_back(i == 0 ? 8'($urandom_range(0, 255)) : pick_payload_byte());
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 3)) stream_buf.push_back(anbs_pkg::BYTE_ZERO);
      end
      // sometimes the final byte is itself a start code
      if ($urandom_range(0, 6) == 0) push_code($urandom_range(0, 1));
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: stall pattern
  // --------------------------------------------------------------------------
  int rx_mode      = 0;
  int rx_mode_left = 0;
  int rx_run_left  = 0;
  bit rx_phase     = 1'b1;

  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= $urandom_range(0, 2);
      rx_mode_left <= $urandom_range(50, 300);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 9) < 7);
      default: begin
        if (rx_run_left == 0) begin
          rx_phase    <= ~rx_phase;
          rx_run_left <= $urandom_range(1, 20);
          out_tready  <= ~rx_phase;
        end else begin
          rx_run_left <= rx_run_left - 1;
          out_tready  <= rx_phase;
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Descriptor check
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input longint unsigned exp_v,
                                      input longint unsigned act_v);
    if (exp_v != act_v) begin
      if (mismatches < REPORT_LIMIT)
        $display("mismatch %s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    unit_desc_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_units.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected descriptor %0h", out_tdata);
        mismatches++;
      end else begin
        e = expected_units.pop_front();
        check_field("unit_index",       e.index,     out_tdata[0 +: anbs_pkg::IDX_W]);
        check_field("unit_offset",      e.offset,
                    out_tdata[anbs_pkg::IDX_W +: anbs_pkg::POS_W]);
        check_field("prefix_length",    e.plen,
                    out_tdata[anbs_pkg::IDX_W + anbs_pkg::POS_W +: anbs_pkg::PLEN_W]);
        check_field("forbidden_zero",   e.forbidden, out_tdata[HDR_LSB]);
        check_field("reference_idc",    e.ref_idc,
                    out_tdata[HDR_LSB + 1 +: anbs_pkg::REF_W]);
        check_field("unit_type",        e.nal_type,
                    out_tdata[HDR_LSB + 1 + anbs_pkg::REF_W +: anbs_pkg::TYPE_W]);
        check_field("payload_length",   e.length,      out_tdata[LEN_LSB +: LEN_BITS]);
        check_field("length_saturated", e.saturated,   out_tdata[LEN_LSB + LEN_BITS]);
        check_field("framing_error",    e.framing_err, out_tdata[LEN_LSB + LEN_BITS + 1]);
      end
    end
  end

  // Abort when neither side has moved a transfer for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Both prefix forms, an empty unit and a start code on the final byte
  task automatic test_prefix_forms();
    stream_buf = '{8'h00, 8'h00, 8'h01, 8'h67, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h01,
                   8'hE5, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01};
    send_stream();
    stream_buf = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h1F};
    send_stream();
  endtask

  // Bad leading prefix with held zeros at the end, and a stream with no unit
  task automatic test_framing();
    stream_buf = '{8'hFF, 8'h00, 8'h00, 8'h01, 8'h41, 8'h80, 8'h00};
    send_stream();
    stream_buf = '{8'h00, 8'h00, 8'h00};
    send_stream();
  endtask

  // Long units, with a zero run inside that turns out not to be a start code
  task automatic test_long_units();
    stream_buf.delete();
    push_code(1'b0);
    repeat (200) stream_buf.push_back(8'hAA);
    stream_buf.push_back(anbs_pkg::BYTE_ZERO);
    stream_buf.push_back(anbs_pkg::BYTE_ZERO);
    stream_buf.push_back(8'h02);
    push_code(1'b1);
    repeat (120) stream_buf.push_back(8'h55);
    send_stream();
  endtask

  // Random streams, pausing now and then until every descriptor is out
  task automatic test_random_streams();
    int start_items;
    int n_streams;
    start_items = items_sent;
    n_streams   = 0;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      build_random_stream();
      send_stream();
      n_streams++;
      if (n_streams % 8 == 0) wait_drained();
    end
  endtask

  initial begin
    restart_parser();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_prefix_forms();
    test_framing();
    test_long_units();
    test_random_streams();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_units.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
